[rtl/pvb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvb_pkg
// Shared constants, types and tables of the pentatonic voice bank: the sine
// table, note frequencies and steps, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package pvb_pkg;

  localparam int PVB_MAX_VOICES  = 256;
  localparam int PVB_FS_HZ       = 48000;
  localparam int WAVE_TABLE_SIZE = 1024;
  localparam int WAVE_IDX_W      = $clog2(WAVE_TABLE_SIZE);

  // dividend of the norm division: 2^32
  localparam int DIV_W = 33;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [21:0] OCT_Q16     = 22'd786432;
  localparam logic [7:0]  SEMIS       = 8'd12;

  localparam logic [16:0] GAIN_RST    = 17'd19661;
  localparam logic [6:0]  BASE_RST    = 7'd48;
  localparam logic [5:0]  SPAN_RST    = 6'd36;
  localparam logic [23:0] ATTACK_RST  = 24'd3495;
  localparam logic [23:0] RELEASE_RST = 24'd1165;

  typedef enum logic [2:0] {
    CFG_GAIN    = 3'd0,
    CFG_BASE    = 3'd1,
    CFG_SPAN    = 3'd2,
    CFG_SHAPE   = 3'd3,
    CFG_ATTACK  = 3'd4,
    CFG_RELEASE = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [22:0] {
    ST_IDLE = 23'h000001,
    ST_CLR  = 23'h000002,
    ST_DIV  = 23'h000004,
    ST_SQRT = 23'h000008,
    ST_LMUL = 23'h000010,
    ST_LLD  = 23'h000020,
    ST_LOCT = 23'h000040,
    ST_LDEG = 23'h000080,
    ST_LWR  = 23'h000100,
    ST_TADR = 23'h000200,
    ST_TLV  = 23'h000400,
    ST_TIX  = 23'h000800,
    ST_TROM = 23'h001000,
    ST_TMX  = 23'h002000,
    ST_TACC = 23'h004000,
    ST_SABS = 23'h008000,
    ST_SM1A = 23'h010000,
    ST_SM1B = 23'h020000,
    ST_SM1C = 23'h040000,
    ST_SM2A = 23'h080000,
    ST_SM2B = 23'h100000,
    ST_SM2C = 23'h200000,
    ST_SPAR = 23'h400000
  } state_t;

  typedef logic signed [16:0] wave_t;
  typedef wave_t sine_tab_t [WAVE_TABLE_SIZE];
  typedef logic [31:0] step_tab_t [256];

  // Q2.15 sine of one table point, Taylor series in Q30
  function automatic wave_t sine_point(input int unsigned idx);
    logic [63:0] four, qd, q, r, x, x2, t, v;
    longint acc;
    wave_t w;
    four = 64'(idx) * 64'd4;
    qd = four / WAVE_TABLE_SIZE;
    q = qd & 64'd3;
    r = four - qd * WAVE_TABLE_SIZE;
    x = HALF_PI_Q30 * r / WAVE_TABLE_SIZE;
    x2 = (x * x) >> 30;
    if (q[0] == 1'b0) begin
      t = x; acc = longint'(x);
      t = ((t * x2) >> 30) / 6;   acc = acc - longint'(t);
      t = ((t * x2) >> 30) / 20;  acc = acc + longint'(t);
      t = ((t * x2) >> 30) / 42;  acc = acc - longint'(t);
      t = ((t * x2) >> 30) / 72;  acc = acc + longint'(t);
      t = ((t * x2) >> 30) / 110; acc = acc - longint'(t);
      t = ((t * x2) >> 30) / 156; acc = acc + longint'(t);
    end else begin
      t = 64'd1 << 30; acc = longint'(t);
      t = ((t * x2) >> 30) / 2;   acc = acc - longint'(t);
      t = ((t * x2) >> 30) / 12;  acc = acc + longint'(t);
      t = ((t * x2) >> 30) / 30;  acc = acc - longint'(t);
      t = ((t * x2) >> 30) / 56;  acc = acc + longint'(t);
      t = ((t * x2) >> 30) / 90;  acc = acc - longint'(t);
      t = ((t * x2) >> 30) / 132; acc = acc + longint'(t);
      t = ((t * x2) >> 30) / 182; acc = acc - longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    v = (64'(acc) + 64'd16384) >> 15;
    w = wave_t'(v[16:0]);
    return q[1] ? -w : w;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i < WAVE_TABLE_SIZE; i++) begin
      tab[i] = sine_point(i);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // octave-0 note frequencies, Q.24 Hz
  function automatic logic [27:0] freq_q24(input logic [3:0] n);
    logic [27:0] f;
    case (n)
      4'd0:    f = 28'd137167144;
      4'd1:    f = 28'd145323527;
      4'd2:    f = 28'd153964914;
      4'd3:    f = 28'd163120144;
      4'd4:    f = 28'd172819773;
      4'd5:    f = 28'd183096173;
      4'd6:    f = 28'd193983636;
      4'd7:    f = 28'd205518503;
      4'd8:    f = 28'd217739269;
      4'd9:    f = 28'd230686720;
      4'd10:   f = 28'd244404066;
      4'd11:   f = 28'd258937088;
      default: f = 28'd0;
    endcase
    return f;
  endfunction

  // phase step of every note number at a given output rate, low 32 bits
  function automatic step_tab_t build_step_tab(input int fs);
    step_tab_t tab;
    logic [63:0] f;
    for (int n = 0; n < 256; n++) begin
      f = 64'(freq_q24(4'(n % 12))) << (n / 12 + 8);
      f = f / 64'(fs);
      tab[n] = f[31:0];
    end
    return tab;
  endfunction

  // snap a Q.16 semitone offset within the octave to a pentatonic degree
  function automatic logic [7:0] note_degree(input logic [21:0] w);
    logic [7:0] d;
    if (w <= 22'd65536)       d = 8'd0;
    else if (w <= 22'd196608) d = 8'd2;
    else if (w <= 22'd360448) d = 8'd4;
    else if (w <= 22'd524288) d = 8'd7;
    else                      d = 8'd9;
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/pentatonic_voice_bank_synth_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pentatonic_voice_bank_synth_unit
// Voice bank: count, load and tick words run one at a time on a sequencer
// around one shared 32x32 multiplier, a restoring divider and a root unit.
// ----------------------------------------------------------------------------
// Tick: a loop over the active voices, then the scale steps; the
//   sample strobe is high in the first cycle in which busy is low.
// Count: clears each newly added voice, then 33 divide and 17 root
//   steps unless the new count is zero. Load: multiply, octave and degree steps, then the step write.
// busy is high while a word is in work; the sample cannot be stalled.
// Synchronous reset clears control state and the configuration registers;
// voice RAMs are not cleared, phase, level and goal are zeroed at switch-on.
module pentatonic_voice_bank_synth_unit
  import pvb_pkg::*;
#(
  parameter int MAX_VOICES = PVB_MAX_VOICES,
  parameter int FS_HZ      = PVB_FS_HZ
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_op,
  input  wire logic [7:0]         in_voice_index,
  input  wire logic [8:0]         in_voice_count,
  input  wire logic [15:0]        in_y_position,
  input  wire logic [7:0]         in_connection_count,
  output logic                    out_valid,
  output logic signed [23:0]      out_audio_sample,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  localparam int CW    = $clog2(MAX_VOICES + 1);
  localparam int IW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int DVW   = CW;
  localparam int SUM_W = 43 + CW;

  localparam step_tab_t STEP_TAB = build_step_tab(FS_HZ);

  state_t state_r;

  logic [16:0] gain_r;
  logic [6:0]  base_r;
  logic [5:0]  span_r;
  logic        shape_r;
  logic [23:0] attack_r, release_r;

  logic [CW-1:0] active_r, cnt_r, ci_r, vi_r;
  logic [15:0]   norm_r;

  logic [IW-1:0] ld_idx_r;
  logic [15:0]   y_r;
  logic [7:0]    goal_r;
  logic [21:0]   w_r;
  logic [7:0]    nt_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, prod_r, lo_r, x_r;

  // divider
  logic [DVW-1:0]   div_rem_r, div_d_r;
  logic [DIV_W-1:0] div_q_r;
  logic [5:0]       div_cnt_r;
  logic [DVW:0]     div_t;
  logic             div_ge;
  logic [DVW-1:0]   div_rem_nxt;
  logic [DIV_W-1:0] div_q_nxt;
  logic             div_last;

  // square root
  logic [32:0] sq_v_r;
  logic [33:0] sq_r_r, sq_b_r;
  logic [34:0] sq_sum;
  logic        sq_ge;
  logic [33:0] sq_r_nxt;

  // tick datapath
  logic [31:0]             rd_phase_r, rd_step_r;
  logic [23:0]             rd_level_r, lv_r;
  logic [7:0]              rd_goal_r;
  logic                    up_r, wneg_r, neg_r;
  wave_t                   rom_rd_r;
  logic signed [SUM_W-1:0] sum_r;

  logic [23:0]        lv_goal, lv_diff;
  logic               lv_up;
  logic signed [17:0] tri_p, tri_mag, wave;
  logic               wave_neg;
  logic [15:0]        wave_mag;
  logic [63:0]        scale_p, out_m;
  logic [CW-1:0]      cnt_in;
  logic               ld_ok, clr_go;

  // memory write controls
  logic          pl_we, goal_we, step_we;
  logic [IW-1:0] pl_wa, goal_wa, rd_addr;
  logic [31:0]   phase_wd;
  logic [23:0]   level_wd;
  logic [7:0]    goal_wd;

  logic [31:0] phase_mem [MAX_VOICES];
  logic [31:0] step_mem  [MAX_VOICES];
  logic [23:0] level_mem [MAX_VOICES];
  logic [7:0]  goal_mem  [MAX_VOICES];

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign cnt_in = (32'(in_voice_count) > 32'(MAX_VOICES)) ? CW'(MAX_VOICES)
                                                          : CW'(in_voice_count);
  assign ld_ok  = 32'(in_voice_index) < 32'(active_r);
  assign clr_go = ci_r < cnt_r;

  // ---- divider step ----
  assign div_t       = {div_rem_r, div_q_r[DIV_W-1]};
  assign div_ge      = div_t >= {1'b0, div_d_r};
  assign div_rem_nxt = div_ge ? DVW'(div_t - {1'b0, div_d_r}) : div_t[DVW-1:0];
  assign div_q_nxt   = {div_q_r[DIV_W-2:0], div_ge};
  assign div_last    = (div_cnt_r == 6'(DIV_W - 1));

  // ---- root step ----
  assign sq_sum   = 35'(sq_r_r) + 35'(sq_b_r);
  assign sq_ge    = 35'(sq_v_r) >= sq_sum;
  assign sq_r_nxt = sq_ge ? ((sq_r_r >> 1) + sq_b_r) : (sq_r_r >> 1);

  // ---- level and wave ----
  assign lv_goal = {rd_goal_r, 16'd0};
  assign lv_up   = lv_goal > rd_level_r;
  assign lv_diff = lv_up ? (lv_goal - rd_level_r) : (rd_level_r - lv_goal);

  assign tri_p    = $signed({2'b00, rd_phase_r[31:16]}) - 18'sd32768;
  assign tri_mag  = tri_p[17] ? -tri_p : tri_p;
  assign wave     = shape_r ? (18'sd32768 - (tri_mag <<< 1)) : 18'(rom_rd_r);
  assign wave_neg = wave[17];
  assign wave_mag = wave_neg ? 16'(-wave) : wave[15:0];

  assign scale_p = lo_r + {prod_r[31:0], 32'd0};
  assign out_m   = scale_p >> 23;

  // ---- shared multiplier operands ----
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      ST_LMUL: begin
        mul_a = 32'(y_r);
        mul_b = 32'(span_r);
      end
      ST_TLV: begin
        mul_a = 32'(lv_diff);
        mul_b = lv_up ? 32'(attack_r) : 32'(release_r);
      end
      ST_TIX: begin
        mul_a = rd_phase_r;
        mul_b = 32'(WAVE_TABLE_SIZE);
      end
      ST_TMX: begin
        mul_a = 32'(wave_mag);
        mul_b = 32'(lv_r);
      end
      ST_SM1A: begin
        mul_a = x_r[31:0];
        mul_b = 32'(gain_r);
      end
      ST_SM1B: begin
        mul_a = x_r[63:32];
        mul_b = 32'(gain_r);
      end
      ST_SM2A: begin
        mul_a = x_r[31:0];
        mul_b = 32'(norm_r);
      end
      ST_SM2B: begin
        mul_a = x_r[63:32];
        mul_b = 32'(norm_r);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r   <= mul_p;
    rom_rd_r <= SINE_TAB[prod_r[32 +: WAVE_IDX_W]];
  end

  // ---- voice RAMs ----
  assign rd_addr  = IW'(vi_r);
  assign pl_we    = ((state_r == ST_CLR) && clr_go) || (state_r == ST_TACC);
  assign pl_wa    = (state_r == ST_CLR) ? IW'(ci_r) : IW'(vi_r);
  assign phase_wd = (state_r == ST_CLR) ? 32'd0 : (rd_phase_r + rd_step_r);
  assign level_wd = (state_r == ST_CLR) ? 24'd0 : lv_r;
  assign step_we  = (state_r == ST_LWR);
  assign goal_we  = ((state_r == ST_CLR) && clr_go) || step_we;
  assign goal_wa  = (state_r == ST_CLR) ? IW'(ci_r) : ld_idx_r;
  assign goal_wd  = (state_r == ST_CLR) ? 8'd0 : goal_r;

  always_ff @(posedge clk) begin
    if (pl_we) begin
      phase_mem[pl_wa] <= phase_wd;
      level_mem[pl_wa] <= level_wd;
    end
    if (step_we) begin
      step_mem[ld_idx_r] <= STEP_TAB[nt_r];
    end
    if (goal_we) begin
      goal_mem[goal_wa] <= goal_wd;
    end
    rd_phase_r <= phase_mem[rd_addr];
    rd_step_r  <= step_mem[rd_addr];
    rd_level_r <= level_mem[rd_addr];
    rd_goal_r  <= goal_mem[rd_addr];
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RST;
      base_r    <= BASE_RST;
      span_r    <= SPAN_RST;
      shape_r   <= 1'b0;
      attack_r  <= ATTACK_RST;
      release_r <= RELEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GAIN:    gain_r    <= cfg_data[16:0];
        CFG_BASE:    base_r    <= cfg_data[6:0];
        CFG_SPAN:    span_r    <= cfg_data[5:0];
        CFG_SHAPE:   shape_r   <= cfg_data[0];
        CFG_ATTACK:  attack_r  <= cfg_data;
        CFG_RELEASE: release_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- sequencer and datapath registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      active_r  <= '0;
      norm_r    <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            case (op_t'(in_op))
              OP_COUNT: begin
                cnt_r   <= cnt_in;
                ci_r    <= active_r;
                state_r <= ST_CLR;
              end
              OP_LOAD: begin
                ld_idx_r <= IW'(in_voice_index);
                y_r      <= in_y_position;
                goal_r   <= in_connection_count;
                if (ld_ok) state_r <= ST_LMUL;
              end
              OP_TICK: begin
                vi_r    <= '0;
                sum_r   <= '0;
                state_r <= (active_r == '0) ? ST_SABS : ST_TADR;
              end
              default: ;
            endcase
          end
        end
        ST_CLR: begin
          if (clr_go) begin
            ci_r <= ci_r + 1'b1;
          end else begin
            active_r <= cnt_r;
            if (cnt_r == '0) begin
              norm_r  <= 16'd0;
              state_r <= ST_IDLE;
            end else begin
              div_rem_r <= '0;
              div_q_r   <= DIV_W'(64'd1 << 32);
              div_d_r   <= DVW'(cnt_r);
              div_cnt_r <= '0;
              state_r   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_last) begin
            sq_v_r  <= div_q_nxt[32:0];
            sq_r_r  <= '0;
            sq_b_r  <= 34'd1 << 32;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_ge) sq_v_r <= 33'(35'(sq_v_r) - sq_sum);
          sq_r_r <= sq_r_nxt;
          sq_b_r <= sq_b_r >> 2;
          if (sq_b_r == 34'd1) begin
            norm_r  <= 16'((sq_r_nxt + 34'd1) >> 1);
            state_r <= ST_IDLE;
          end
        end
        ST_LMUL: state_r <= ST_LLD;
        ST_LLD: begin
          w_r     <= prod_r[21:0];
          nt_r    <= 8'(base_r);
          state_r <= ST_LOCT;
        end
        ST_LOCT: begin
          if (w_r >= OCT_Q16) begin
            w_r  <= w_r - OCT_Q16;
            nt_r <= nt_r + SEMIS;
          end else begin
            state_r <= ST_LDEG;
          end
        end
        ST_LDEG: begin
          nt_r    <= nt_r + note_degree(w_r);
          state_r <= ST_LWR;
        end
        // step looked up by note number, goal written alongside
        ST_LWR: state_r <= ST_IDLE;
        ST_TADR: state_r <= ST_TLV;
        ST_TLV: begin
          up_r    <= lv_up;
          state_r <= ST_TIX;
        end
        ST_TIX: begin
          lv_r    <= up_r ? (rd_level_r + prod_r[47:24]) : (rd_level_r - prod_r[47:24]);
          state_r <= ST_TROM;
        end
        ST_TROM: state_r <= ST_TMX;
        ST_TMX: begin
          wneg_r  <= wave_neg;
          state_r <= ST_TACC;
        end
        ST_TACC: begin
          sum_r   <= wneg_r ? (sum_r - SUM_W'(prod_r)) : (sum_r + SUM_W'(prod_r));
          vi_r    <= vi_r + 1'b1;
          state_r <= ((vi_r + 1'b1) == active_r) ? ST_SABS : ST_TADR;
        end
        ST_SABS: begin
          neg_r   <= sum_r[SUM_W-1];
          x_r     <= 64'(sum_r[SUM_W-1] ? -sum_r : sum_r) >> 8;
          state_r <= ST_SM1A;
        end
        ST_SM1A: state_r <= ST_SM1B;
        ST_SM1B: begin
          lo_r    <= prod_r;
          state_r <= ST_SM1C;
        end
        ST_SM1C: begin
          x_r     <= scale_p >> 16;
          state_r <= ST_SM2A;
        end
        ST_SM2A: state_r <= ST_SM2B;
        ST_SM2B: begin
          lo_r    <= prod_r;
          state_r <= ST_SM2C;
        end
        ST_SM2C: begin
          if (neg_r) begin
            out_audio_sample <= (out_m > 64'd8388608) ? -24'sd8388608
                                                     : -$signed(out_m[23:0]);
          end else begin
            out_audio_sample <= (out_m > 64'd8388607) ? 24'sd8388607
                                                     : $signed(out_m[23:0]);
          end
          out_valid <= 1'b1;
          state_r   <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---- assertions ----
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SM2C))
    else $error("sample strobe not preceded by the final scale step");

  a_active_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(active_r) <= 32'(MAX_VOICES))
    else $error("active voice count beyond bank size");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_rem_r < div_d_r))
    else $error("divider remainder not below divisor");

  a_tick_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TACC) |=> (state_r == ST_TADR || state_r == ST_SABS))
    else $error("voice loop left by an unexpected path");

endmodule
`default_nettype wire
